/* hw/rtl/pts_pkg.sv */
// Shared constants and types of the priority task scheduler.
`default_nettype none
package pts_pkg;

  localparam int MaxTasks  = 8;
  localparam int NumLevels = 8;
  localparam int TickW     = 32;
  localparam int SlotW     = 3;
  localparam int LevelW    = 3;
  localparam int CntW      = 4;
  localparam int RingAw    = LevelW + SlotW;
  localparam int RingDepth = NumLevels * MaxTasks;
  localparam int CmdW      = 3;
  localparam int PrioW     = 8;
  localparam int InDataW   = 48;
  localparam int OutDataW  = 104;

  typedef enum logic [CmdW-1:0] {
    CmdCreate = 3'd0,
    CmdStart  = 3'd1,
    CmdDelay  = 3'd2,
    CmdTick   = 3'd3,
    CmdSwitch = 3'd4
  } cmd_e;

endpackage
`default_nettype wire

/* hw/rtl/priority_task_scheduler.sv */
// Top level of the priority task scheduler: command sequencer and state.
//
// One command beat in, one result beat out. The block works on one command at
// a time. The ready rings of all levels live in one 64 x 3 RAM with a
// registered read, and every ring insert or removal moves entries one by one
// through that RAM, so the ring RAM port sets the cost. A rejected create goes
// straight to the result; a create shifts the entries behind the insert
// point, a delay shifts the ring entries behind the current task and files
// it in the sleep list, and a tick puts each task it wakes back in its ring.
// The next command is taken while the previous result still waits on the
// output.
// No clearing pass runs after reset.
`default_nettype none
module priority_task_scheduler
  import pts_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // tdata: task_id[2:0], task_priority[10:3], delay_ticks[42:11], zero fill
  input  wire logic [InDataW-1:0]  s_axis_tdata_i,
  // tuser: cmd[2:0]
  input  wire logic [CmdW-1:0]     s_axis_tuser_i,
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  // tdata: current_task[2:0], current_valid[3], status[4], tick_now[36:5],
  //        next_wake_time[68:37], wrap_count[100:69], zero fill
  output logic [OutDataW-1:0]      m_axis_tdata_o
);

  typedef enum logic [3:0] {
    StIdle, StExec, StTick2, StWake, StAddRd, StAddWr, StDropRd, StDropCmp,
    StShRd, StShWr, StFile, StPick, StPickRd, StDone
  } state_e;

  localparam logic [TickW-1:0] TickOnes = '1;

  state_e state_q, ret_q;

  // captured command
  logic [CmdW-1:0]   cmd_q;
  logic [SlotW-1:0]  id_q;
  logic [PrioW-1:0]  prio_q;
  logic [TickW-1:0]  delay_q;
  logic              status_q;

  // sequencer working registers
  logic [LevelW-1:0] lv_q;
  logic [CntW-1:0]   k_q;
  logic [CntW-1:0]   pos_q;

  // task table and scheduler state
  logic              slot_used_q  [MaxTasks];
  logic [LevelW-1:0] slot_level_q [MaxTasks];
  logic [TickW-1:0]  slot_wake_q  [MaxTasks];
  logic [CntW-1:0]   ring_len_q   [NumLevels];
  logic [CntW-1:0]   ring_cur_q   [NumLevels];
  logic [NumLevels-1:0] ready_bits_q;
  logic [SlotW-1:0]  sl_q     [2][MaxTasks];
  logic [CntW-1:0]   sl_len_q [2];
  logic              near_b_q;
  logic [TickW-1:0]  tick_q, wake_q, wrap_q;
  logic [SlotW-1:0]  run_slot_q;
  logic              run_valid_q;
  logic [CntW-1:0]   total_q;

  logic                m_tvalid_q;
  logic [OutDataW-1:0] m_tdata_q;

  // ring RAM port
  logic              ram_we;
  logic [RingAw-1:0] ram_waddr, ram_raddr;
  logic [SlotW-1:0]  ram_wdata, ram_rdata;

  pts_ram #(.Width(SlotW), .Depth(RingDepth)) u_ring_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // highest non-empty level and its advanced cursor
  logic              pick_found;
  logic [LevelW-1:0] pick_lv;
  logic [CntW-1:0]   pick_p;
  always_comb begin
    pick_found = 1'b0;
    pick_lv    = '0;
    for (int l = 0; l < NumLevels; l++) begin
      if (ready_bits_q[l]) begin
        pick_found = 1'b1;
        pick_lv    = LevelW'(l);
      end
    end
    pick_p = (ring_cur_q[pick_lv] >= ring_len_q[pick_lv]) ? CntW'(1)
                                                          : ring_cur_q[pick_lv] + CntW'(1);
  end

  // head of the near sleep list
  logic [SlotW-1:0] head_id;
  logic [TickW-1:0] head_wake;
  assign head_id   = sl_q[near_b_q][0];
  assign head_wake = slot_wake_q[head_id];

  // ring insert set-up, shared by create and wake-up
  logic [LevelW-1:0] clamp_lv, add_lv;
  logic [SlotW-1:0]  add_id;
  logic [CntW-1:0]   add_n, add_p, add_pos;
  logic              add_mid;
  always_comb begin
    clamp_lv = (prio_q >= PrioW'(NumLevels)) ? LevelW'(NumLevels - 1)
                                             : prio_q[LevelW-1:0];
    add_lv   = (state_q == StWake) ? slot_level_q[head_id] : clamp_lv;
    add_id   = (state_q == StWake) ? head_id : id_q;
    add_n    = ring_len_q[add_lv];
    add_p    = ring_cur_q[add_lv];
    add_mid  = !(add_p == '0 || add_p > add_n);
    add_pos  = add_mid ? add_p - CntW'(1) : add_n;
  end

  // sleep list insert for delay
  logic [TickW-1:0] fw;
  logic             far;
  logic             lsel;
  logic [CntW-1:0]  ins_n, ins_pos;
  always_comb begin
    fw      = tick_q + delay_q;
    far     = fw < tick_q;
    lsel    = near_b_q ^ far;
    ins_n   = sl_len_q[lsel];
    ins_pos = '0;
    for (int e = 0; e < MaxTasks; e++) begin
      if (CntW'(e) < ins_n && slot_wake_q[sl_q[lsel][e]] <= fw) begin
        ins_pos = ins_pos + CntW'(1);
      end
    end
  end

  // ring RAM addressing per sequencer step
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = {lv_q, k_q[SlotW-1:0]};
    ram_wdata = ram_rdata;
    ram_raddr = {lv_q, k_q[SlotW-1:0]};
    case (state_q)
      StAddRd: begin
        ram_raddr = {lv_q, SlotW'(k_q - CntW'(1))};
        if (k_q == pos_q) begin
          ram_we    = 1'b1;
          ram_waddr = {lv_q, pos_q[SlotW-1:0]};
          ram_wdata = id_q;
        end
      end
      StAddWr: ram_we = 1'b1;
      StShRd:  ram_raddr = {lv_q, SlotW'(k_q + CntW'(1))};
      StShWr:  ram_we = 1'b1;
      StPick:  ram_raddr = {pick_lv, SlotW'(pick_p - CntW'(1))};
      default: ;
    endcase
  end

  assign s_axis_tready_o = (state_q == StIdle);
  assign m_axis_tvalid_o = m_tvalid_q;
  assign m_axis_tdata_o  = m_tdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      ret_q        <= StDone;
      m_tvalid_q   <= 1'b0;
      ready_bits_q <= '0;
      near_b_q     <= 1'b0;
      tick_q       <= '0;
      wake_q       <= '0;
      wrap_q       <= '0;
      run_slot_q   <= '0;
      run_valid_q  <= 1'b0;
      total_q      <= '0;
      sl_len_q[0]  <= '0;
      sl_len_q[1]  <= '0;
      for (int t = 0; t < MaxTasks; t++) begin
        slot_used_q[t] <= 1'b0;
      end
      for (int l = 0; l < NumLevels; l++) begin
        ring_len_q[l] <= '0;
        ring_cur_q[l] <= '0;
      end
    end else begin
      // drop the result beat once taken; the done step reloads it itself
      if (m_axis_tready_i && state_q != StDone) begin
        m_tvalid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (s_axis_tvalid_i) begin
            cmd_q    <= s_axis_tuser_i;
            id_q     <= s_axis_tdata_i[2:0];
            prio_q   <= s_axis_tdata_i[10:3];
            delay_q  <= s_axis_tdata_i[42:11];
            status_q <= 1'b0;
            state_q  <= StExec;
          end
        end
        StExec: begin
          case (cmd_q)
            CmdCreate: begin
              if (slot_used_q[id_q] || total_q >= CntW'(MaxTasks)) begin
                status_q <= 1'b1;
                state_q  <= StDone;
              end else begin
                slot_used_q[id_q]  <= 1'b1;
                slot_level_q[id_q] <= clamp_lv;
                slot_wake_q[id_q]  <= '0;
                total_q            <= total_q + CntW'(1);
                if (!run_valid_q) begin
                  run_slot_q  <= id_q;
                  run_valid_q <= 1'b1;
                end else if (slot_level_q[run_slot_q] <= clamp_lv) begin
                  run_slot_q <= id_q;
                end
                ret_q <= StDone;
                if (add_n >= CntW'(MaxTasks)) begin
                  state_q <= StDone;
                end else begin
                  if (add_mid) ring_cur_q[add_lv] <= add_p + CntW'(1);
                  lv_q    <= add_lv;
                  id_q    <= add_id;
                  pos_q   <= add_pos;
                  k_q     <= add_n;
                  state_q <= StAddRd;
                end
              end
            end
            CmdStart: begin
              tick_q  <= '0;
              wake_q  <= TickOnes;
              state_q <= StPick;
            end
            CmdDelay: begin
              if (!run_valid_q) begin
                state_q <= StPick;
              end else begin
                lv_q    <= slot_level_q[run_slot_q];
                id_q    <= run_slot_q;
                k_q     <= '0;
                state_q <= StDropRd;
              end
            end
            CmdTick: begin
              tick_q <= tick_q + TickW'(1);
              if (tick_q == TickOnes) begin
                // counter wraps: far list becomes near
                near_b_q <= !near_b_q;
                wrap_q   <= wrap_q + TickW'(1);
                wake_q   <= (sl_len_q[!near_b_q] == '0) ? TickOnes
                            : slot_wake_q[sl_q[!near_b_q][0]];
              end
              state_q <= StTick2;
            end
            CmdSwitch: state_q <= StPick;
            default:   state_q <= StDone;
          endcase
        end
        StTick2: state_q <= (tick_q < wake_q) ? StPick : StWake;
        StWake: begin
          if (sl_len_q[near_b_q] == '0) begin
            wake_q  <= TickOnes;
            state_q <= StPick;
          end else if (tick_q < head_wake) begin
            wake_q  <= head_wake;
            state_q <= StPick;
          end else begin
            // pop the head and put it back in its ring
            for (int e = 0; e < MaxTasks - 1; e++) begin
              sl_q[near_b_q][e] <= sl_q[near_b_q][e+1];
            end
            sl_len_q[near_b_q] <= sl_len_q[near_b_q] - CntW'(1);
            ret_q <= StWake;
            if (add_n < CntW'(MaxTasks)) begin
              if (add_mid) ring_cur_q[add_lv] <= add_p + CntW'(1);
              lv_q    <= add_lv;
              id_q    <= add_id;
              pos_q   <= add_pos;
              k_q     <= add_n;
              state_q <= StAddRd;
            end
          end
        end
        StAddRd: begin
          if (k_q == pos_q) begin
            ring_len_q[lv_q]   <= ring_len_q[lv_q] + CntW'(1);
            ready_bits_q[lv_q] <= 1'b1;
            state_q            <= ret_q;
          end else begin
            state_q <= StAddWr;
          end
        end
        StAddWr: begin
          k_q     <= k_q - CntW'(1);
          state_q <= StAddRd;
        end
        StDropRd: begin
          state_q <= (k_q == ring_len_q[lv_q]) ? StPick : StDropCmp;
        end
        StDropCmp: begin
          if (ram_rdata == id_q) begin
            pos_q   <= k_q;
            state_q <= StShRd;
          end else begin
            k_q     <= k_q + CntW'(1);
            state_q <= StDropRd;
          end
        end
        StShRd: begin
          if (k_q + CntW'(1) < ring_len_q[lv_q]) begin
            state_q <= StShWr;
          end else begin
            ring_len_q[lv_q] <= ring_len_q[lv_q] - CntW'(1);
            if (ring_len_q[lv_q] == CntW'(1)) begin
              ready_bits_q[lv_q] <= 1'b0;
              ring_cur_q[lv_q]   <= '0;
            end else if (ring_cur_q[lv_q] >= pos_q + CntW'(1)) begin
              ring_cur_q[lv_q] <= ring_cur_q[lv_q] - CntW'(1);
            end
            state_q <= StFile;
          end
        end
        StShWr: begin
          k_q     <= k_q + CntW'(1);
          state_q <= StShRd;
        end
        StFile: begin
          slot_wake_q[id_q] <= fw;
          if (ins_n < CntW'(MaxTasks)) begin
            for (int e = 1; e < MaxTasks; e++) begin
              if (CntW'(e) > ins_pos) sl_q[lsel][e] <= sl_q[lsel][e-1];
            end
            sl_q[lsel][ins_pos[SlotW-1:0]] <= id_q;
            sl_len_q[lsel] <= ins_n + CntW'(1);
          end
          if (!far && fw < wake_q) wake_q <= fw;
          state_q <= StPick;
        end
        StPick: begin
          if (!pick_found) begin
            run_valid_q <= 1'b0;
            state_q     <= StDone;
          end else begin
            ring_cur_q[pick_lv] <= pick_p;
            state_q             <= StPickRd;
          end
        end
        StPickRd: begin
          run_slot_q  <= ram_rdata;
          run_valid_q <= 1'b1;
          state_q     <= StDone;
        end
        StDone: begin
          // hold until the output register is free
          if (!m_tvalid_q || m_axis_tready_i) begin
            m_tvalid_q <= 1'b1;
            m_tdata_q  <= {3'b000, wrap_q, wake_q, tick_q, status_q, run_valid_q,
                           run_valid_q ? run_slot_q : SlotW'(0)};
            state_q    <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/pts_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module pts_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

/* hw/rtl/pts_checker.sv */
// Port-level checker of the priority task scheduler and its bind.
`default_nettype none
module pts_checker
  import pts_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                s_axis_tvalid_i,
  input wire logic                s_axis_tready_o,
  input wire logic [InDataW-1:0]  s_axis_tdata_i,
  input wire logic [CmdW-1:0]     s_axis_tuser_i,
  input wire logic                m_axis_tvalid_o,
  input wire logic                m_axis_tready_i,
  input wire logic [OutDataW-1:0] m_axis_tdata_o
);

  logic       in_beat, out_beat;
  logic [1:0] pend_q;

  assign in_beat  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_beat = m_axis_tvalid_o && m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 2'(in_beat) - 2'(out_beat);
    end
  end

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> pend_q != 2'd0) else $error("result beat without command");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd3) else $error("too many commands in flight");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result beat changed");

  a_idle_task: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[3] |-> m_axis_tdata_o[2:0] == 3'd0)
    else $error("task slot shown without current task");

endmodule

bind priority_task_scheduler pts_checker u_pts_checker (.*);
`default_nettype wire
